[sv/gld_pkg.sv]
`timescale 1ns / 1ps
package gld_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int ADDR_W        = MAX_CODE_BITS;
    localparam int LEN_W         = ADDR_W + 1;
    localparam int TBL_DEPTH     = 1 << ADDR_W;
    localparam int BUF_BITS      = 24;
    localparam int CNT_W         = 5;
    localparam int SIZE_W        = 4;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] MAX_SIZE   = SIZE_W'(MAX_CODE_BITS - 1);
    localparam logic [SIZE_W-1:0] RESET_MCS  = SIZE_W'(8);
    localparam logic [SIZE_W-1:0] MAX_WIDTH  = SIZE_W'(MAX_CODE_BITS);

    // input action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_PUSH  = 2'd1;
    localparam logic [1:0] ACT_PULL  = 2'd2;

    typedef enum logic [1:0] {
        K_START = 2'd0,
        K_PUSH  = 2'd1,
        K_PULL  = 2'd2,
        K_NOP   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] pixel;
        logic       pixel_valid;
        logic       need_data;
        logic       end_of_image;
        logic       code_error;
        logic       push_dropped;
    } t_out;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
    } t_cmd;

    // queue handshake toward the decode engine
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (r > MAX_SIZE) r = MAX_SIZE;
        if (r < MIN_SIZE) r = MIN_SIZE;
        return r;
    endfunction

endpackage

[sv/gld_ram.sv]
`timescale 1ns / 1ps
module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/gld_front.sv]
`timescale 1ns / 1ps
module gld_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gld_pkg::t_in  i_in_data,
    output gld_pkg::t_cmd_q o_q,
    input  logic          i_pop
);
    import gld_pkg::*;

    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push, w_pop;

    // classify the action of an incoming beat
    always_comb begin
        w_cmd.data_byte = i_in_data.data_byte;
        unique case (i_in_data.action)
            ACT_START: w_cmd.kind = K_START;
            ACT_PUSH:  w_cmd.kind = K_PUSH;
            ACT_PULL:  w_cmd.kind = K_PULL;
            default:   w_cmd.kind = K_NOP;
        endcase
    end

    assign o_in_ready = (r_cnt != 2'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_pop && (r_cnt != 2'd0);
    assign o_q        = '{valid: (r_cnt != 2'd0), cmd: r_q[r_rp]};

    // store classified commands
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

[sv/gld_back.sv]
`timescale 1ns / 1ps
module gld_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gld_pkg::t_cmd_q  i_q,
    output logic             o_pop,
    input  logic             i_cfg_valid,
    input  logic [3:0]       i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output gld_pkg::t_out    o_out_data
);
    import gld_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOOP  = 8'b0000_0010,
        S_LOLD  = 8'b0000_0100,
        S_LCODE = 8'b0000_1000,
        S_UNW   = 8'b0001_0000,
        S_FIN   = 8'b0010_0000,
        S_POP   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_st, n_st;
    logic [SIZE_W-1:0]   r_mcs, n_mcs, r_size, n_size, r_width, n_width;
    logic [BUF_BITS-1:0] r_buf, n_buf;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [LEN_W-1:0]    r_next, n_next, r_sp, n_sp;
    logic [ADDR_W-1:0]   r_prev, n_prev, r_code, n_code, r_uc, n_uc;
    logic [LEN_W-1:0]    r_newlen, n_newlen, r_n, n_n, r_i, n_i;
    logic [7:0]          r_first, n_first, r_pix, n_pix;
    logic                r_ended, n_ended, r_err, n_err, r_drop, n_drop, r_pv, n_pv;
    logic                r_ovalid, n_ovalid;
    t_out                r_out, n_out;

    logic [ADDR_W-1:0] w_clear, w_eoi, w_nxt, w_cmask, w_craw, w_pre;
    logic [7:0]        w_suf;
    logic [LEN_W-1:0]  w_lenold, w_n, w_inc, w_sptop;
    logic              w_can_load;

    // table ports
    logic              w_pre_we, w_suf_we, w_len_we, w_stk_we;
    logic [ADDR_W-1:0] w_sp_raddr, w_len_raddr, w_stk_raddr, w_stk_waddr;
    logic [7:0]        w_stk_wdata;
    logic [ADDR_W-1:0] w_pre_rdata;
    logic [7:0]        w_suf_rdata, w_stk_rdata;
    logic [LEN_W-1:0]  w_len_rdata;

    assign w_clear  = ADDR_W'(1) << r_size;
    assign w_eoi    = w_clear + ADDR_W'(1);
    assign w_nxt    = r_next[ADDR_W-1:0];
    assign w_cmask  = ADDR_W'((LEN_W'(1) << r_width) - LEN_W'(1));
    assign w_craw   = r_buf[ADDR_W-1:0] & w_cmask;
    assign w_sptop  = r_sp - LEN_W'(1);
    assign w_lenold = (r_prev < w_clear) ? LEN_W'(1) : w_len_rdata;
    assign w_suf    = (r_uc < w_clear) ? r_uc[7:0] : w_suf_rdata;
    // the new entry's link was written in the same cycle it was read
    assign w_pre    = (r_uc < w_clear) ? '0 :
                      (r_i == '0 && r_code == w_nxt) ? r_prev : w_pre_rdata;
    assign w_n      = (r_code < w_clear) ? LEN_W'(1) :
                      (r_code == w_nxt)  ? r_newlen  : w_len_rdata;
    assign w_inc    = r_next + LEN_W'(1);
    assign w_can_load = !r_ovalid || i_out_ready;
    assign o_pop    = (r_st == S_IDLE) && i_q.valid;

    // tables
    gld_ram #(.WIDTH(ADDR_W), .DEPTH(TBL_DEPTH)) u_prefix (
        .i_clk(i_clk), .i_we(w_pre_we), .i_waddr(w_nxt), .i_wdata(r_prev),
        .i_raddr(w_sp_raddr), .o_rdata(w_pre_rdata));
    gld_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_suffix (
        .i_clk(i_clk), .i_we(w_suf_we), .i_waddr(w_nxt), .i_wdata(r_first),
        .i_raddr(w_sp_raddr), .o_rdata(w_suf_rdata));
    gld_ram #(.WIDTH(LEN_W), .DEPTH(TBL_DEPTH)) u_length (
        .i_clk(i_clk), .i_we(w_len_we), .i_waddr(w_nxt), .i_wdata(r_newlen),
        .i_raddr(w_len_raddr), .o_rdata(w_len_rdata));
    gld_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(w_stk_we), .i_waddr(w_stk_waddr), .i_wdata(w_stk_wdata),
        .i_raddr(w_stk_raddr), .o_rdata(w_stk_rdata));

    // sequencer: start images, buffer pushed bytes, decode codes, unwind strings, pop pixels
    always_comb begin
        n_st = r_st;  n_mcs = r_mcs;  n_size = r_size;  n_width = r_width;
        n_buf = r_buf;  n_cnt = r_cnt;  n_next = r_next;  n_sp = r_sp;
        n_prev = r_prev;  n_code = r_code;  n_uc = r_uc;  n_newlen = r_newlen;
        n_n = r_n;  n_i = r_i;  n_first = r_first;  n_pix = r_pix;
        n_ended = r_ended;  n_err = r_err;  n_drop = r_drop;  n_pv = r_pv;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out = r_out;
        w_pre_we = 1'b0;  w_suf_we = 1'b0;  w_len_we = 1'b0;  w_stk_we = 1'b0;
        w_sp_raddr = r_uc;  w_len_raddr = r_prev;  w_stk_raddr = w_sptop[ADDR_W-1:0];
        w_stk_waddr = r_i[ADDR_W-1:0];  w_stk_wdata = w_suf;

        if (i_cfg_valid) n_mcs = i_cfg_data;

        unique case (r_st)
            S_IDLE: begin
                if (i_q.valid) begin
                    n_err = 1'b0;  n_drop = 1'b0;  n_pv = 1'b0;  n_pix = 8'd0;
                    n_st = S_DONE;
                    case (i_q.cmd.kind)
                        K_START: begin
                            n_size  = clamp_size(r_mcs);
                            n_width = n_size + SIZE_W'(1);
                            n_next  = (LEN_W'(1) << n_size) + LEN_W'(1);
                            n_prev  = ADDR_W'(1) << n_size;
                            n_sp = '0;  n_buf = '0;  n_cnt = '0;  n_ended = 1'b0;
                        end
                        K_PUSH: begin
                            if (!r_ended) begin
                                if (r_cnt > CNT_W'(BUF_BITS - 8)) begin
                                    n_drop = 1'b1;
                                end else begin
                                    n_buf = r_buf | (BUF_BITS'(i_q.cmd.data_byte) << r_cnt);
                                    n_cnt = r_cnt + CNT_W'(8);
                                end
                            end
                        end
                        K_PULL:  n_st = S_LOOP;
                        default: n_st = S_DONE;
                    endcase
                end
            end
            S_LOOP: begin
                if (!r_ended && r_sp == '0 && r_cnt >= CNT_W'(r_width)) begin
                    n_buf = r_buf >> r_width;
                    n_cnt = r_cnt - CNT_W'(r_width);
                    if (w_craw == w_clear) begin
                        n_width = r_size + SIZE_W'(1);
                        n_next  = LEN_W'(w_eoi);
                        n_prev  = w_clear;
                    end else if (w_craw == w_eoi) begin
                        n_ended = 1'b1;
                    end else begin
                        n_code = w_craw;
                        if (LEN_W'(w_craw) > r_next && r_next != LEN_W'(w_clear)) begin
                            n_err  = 1'b1;
                            n_code = '0;
                        end
                        n_st = S_LOLD;
                    end
                end else if (r_sp != '0) begin
                    n_sp = w_sptop;
                    n_st = S_POP;
                end else begin
                    n_st = S_DONE;
                end
            end
            S_LOLD: begin
                // size the new entry from the previous code's length
                n_newlen    = w_lenold + LEN_W'(1);
                w_len_raddr = r_code;
                n_st        = S_LCODE;
            end
            S_LCODE: begin
                w_pre_we   = 1'b1;
                w_len_we   = 1'b1;
                n_n        = (w_n > LEN_W'(TBL_DEPTH)) ? LEN_W'(TBL_DEPTH) : w_n;
                n_i        = '0;
                n_first    = 8'd0;
                w_sp_raddr = r_code;
                n_uc       = r_code;
                n_st       = (n_n == '0) ? S_FIN : S_UNW;
            end
            S_UNW: begin
                // one link a beat onto the stack
                w_stk_we   = 1'b1;
                n_first    = w_suf;
                n_i        = r_i + LEN_W'(1);
                w_sp_raddr = w_pre;
                n_uc       = w_pre;
                if (n_i == r_n) n_st = S_FIN;
            end
            S_FIN: begin
                w_suf_we    = 1'b1;
                w_stk_waddr = '0;
                w_stk_wdata = r_first;
                w_stk_we    = (r_code == w_nxt) && (r_n != '0);
                n_sp        = r_n;
                n_prev      = r_code;
                if (r_next != LEN_W'(w_clear)) begin
                    n_next = w_inc;
                    if (w_inc == (LEN_W'(1) << r_width)) begin
                        if (r_width < MAX_WIDTH) n_width = r_width + SIZE_W'(1);
                        else                     n_next  = LEN_W'(w_clear);
                    end
                end
                n_st = S_LOOP;
            end
            S_POP: begin
                n_pix = w_stk_rdata;
                n_pv  = 1'b1;
                n_st  = S_DONE;
            end
            S_DONE: begin
                if (w_can_load) begin
                    n_ovalid          = 1'b1;
                    n_out.pixel        = r_pix;
                    n_out.pixel_valid  = r_pv;
                    n_out.need_data    = !r_ended && r_sp == '0 && r_cnt < CNT_W'(r_width);
                    n_out.end_of_image = r_ended;
                    n_out.code_error   = r_err;
                    n_out.push_dropped = r_drop;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;  r_mcs <= RESET_MCS;  r_size <= RESET_MCS;
            r_width <= RESET_MCS + SIZE_W'(1);
            r_next <= (LEN_W'(1) << RESET_MCS) + LEN_W'(1);
            r_prev <= ADDR_W'(1) << RESET_MCS;
            r_buf <= '0;  r_cnt <= '0;  r_sp <= '0;  r_ended <= 1'b0;  r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;  r_mcs <= n_mcs;  r_size <= n_size;  r_width <= n_width;
            r_next <= n_next;  r_prev <= n_prev;  r_buf <= n_buf;  r_cnt <= n_cnt;
            r_sp <= n_sp;  r_ended <= n_ended;  r_ovalid <= n_ovalid;
        end
    end

    // hold working payload
    always_ff @(posedge i_clk) begin
        r_code <= n_code;  r_uc <= n_uc;  r_newlen <= n_newlen;  r_n <= n_n;
        r_i <= n_i;  r_first <= n_first;  r_pix <= n_pix;  r_err <= n_err;
        r_drop <= n_drop;  r_pv <= n_pv;  r_out <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule

[sv/gif_lzw_decoder.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Beat
// in      | input     | i_in_valid/o_in_ready  | t_in  (action, data_byte)
// out     | output    | o_out_valid/i_out_ready| t_out (pixel and status flags)
// cfg     | input     | i_cfg_valid/o_cfg_ready| minimum code size, 4 bits
//
// A start, push or idle beat goes from idle straight to the output state; a pull
// popping a buffered pixel passes loop and pop; a pull that decodes a code reads
// two lengths, walks the prefix links at one table read a cycle (one per string
// byte), with a loop pass per clear code. The queue registers each beat.
// Reset (synchronous, active low) gives an image start with min code size 8.
// A two-beat queue takes input while the decoder works or the output waits.
module gif_lzw_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gld_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gld_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_data
);
    import gld_pkg::*;

    t_cmd_q w_q;
    logic   w_pop;

    assign o_cfg_ready = 1'b1;

    gld_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_in_data(i_in_data), .o_q(w_q), .i_pop(w_pop));

    gld_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q(w_q), .o_pop(w_pop),
        .i_cfg_valid(i_cfg_valid), .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data));
endmodule
